### sv/sbcc_pkg.sv
// Package for the SCSI block command checker: codes, the command and result
// structures and the decode types. No dependencies.
`default_nettype none
package sbcc_pkg;
  localparam logic [3:0] ERR_GOOD      = 4'd0;
  localparam logic [3:0] ERR_CHANGED   = 4'd1;
  localparam logic [3:0] ERR_NOT_READY = 4'd2;
  localparam logic [3:0] ERR_FIELD     = 4'd3;
  localparam logic [3:0] ERR_RANGE     = 4'd4;
  localparam logic [3:0] ERR_PROTECT   = 4'd5;
  localparam logic [3:0] ERR_NO_MEDIUM = 4'd6;
  localparam logic [3:0] ERR_EJECT     = 4'd7;
  localparam logic [3:0] ERR_OPCODE    = 4'd8;

  localparam logic [1:0] PH_STATUS = 2'd0;
  localparam logic [1:0] PH_IN     = 2'd1;
  localparam logic [1:0] PH_OUT    = 2'd2;

  // Operation classes found by the front end.
  localparam logic [3:0] OP_NONE   = 4'd0;
  localparam logic [3:0] OP_CHANGE = 4'd1;
  localparam logic [3:0] OP_FORMAT = 4'd2;
  localparam logic [3:0] OP_XFER   = 4'd3;
  localparam logic [3:0] OP_SEEK   = 4'd4;
  localparam logic [3:0] OP_LONG   = 4'd5;
  localparam logic [3:0] OP_CAP    = 4'd6;
  localparam logic [3:0] OP_STSP   = 4'd7;
  localparam logic [3:0] OP_DIAG   = 4'd8;
  localparam logic [3:0] OP_LOCK   = 4'd9;
  localparam logic [3:0] OP_BADOP  = 4'd10;
  localparam logic [3:0] OP_BADSA  = 4'd11;

  localparam logic [1:0] K_READ   = 2'd0;
  localparam logic [1:0] K_WRITE  = 2'd1;
  localparam logic [1:0] K_VERIFY = 2'd2;

  localparam logic [2:0] REG_TOTAL   = 3'd0;
  localparam logic [2:0] REG_SHIFT   = 3'd1;
  localparam logic [2:0] REG_PROTECT = 3'd2;
  localparam logic [2:0] REG_READY   = 3'd3;
  localparam logic [2:0] REG_REMOV   = 3'd4;

  localparam int QDEPTH = 2;

  typedef struct packed {
    logic [3:0]  op;
    logic [1:0]  kind;
    logic        wide;
    logic [63:0] start;
    logic [32:0] count;
    logic        len_nz;
    logic        bytchk;
    logic        fmt_bad;
    logic        diag_bad;
    logic [7:0]  b4;
  } cls_t;

  typedef struct packed {
    logic [47:0] block_total;
    logic [3:0]  sector_shift;
    logic        wr_protect;
    logic        medium_ready;
    logic        removable;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  error;
    logic [1:0]  phase;
    logic [63:0] start_block;
    logic [31:0] block_count;
    logic [12:0] transfer_bytes;
    logic [63:0] last_block;
    logic [12:0] block_bytes;
    logic        flush_request;
    logic        eject_request;
    logic        unit_stopped;
  } res_t;
endpackage
`default_nettype wire

### sv/sbcc_front.sv
// Front end of the SCSI block command checker: decodes a descriptor into a
// class record and pushes it into a two-entry queue. Uses sbcc_pkg.
`default_nettype none
module sbcc_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [127:0]  in_tdata,
  input  wire logic          in_tuser,
  input  wire logic          q_pop,
  output logic               q_valid,
  output sbcc_pkg::cls_t     q_data
);
  logic [7:0]  cmd;
  logic [63:0] hd;
  logic [55:0] tl;
  logic [7:0]  b [1:15];
  sbcc_pkg::cls_t c;
  sbcc_pkg::cls_t mem_r [0:sbcc_pkg::QDEPTH-1];
  logic wp_r, rp_r, wp_nxt, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic push;

  assign cmd = in_tdata[7:0];
  assign hd  = in_tdata[71:8];
  assign tl  = in_tdata[127:72];

  always_comb begin
    for (int i = 1; i <= 8; i++) b[i] = hd[(8-i)*8 +: 8];
    for (int i = 9; i <= 15; i++) b[i] = tl[(15-i)*8 +: 8];
  end

  always_comb begin
    c = '0;
    c.b4 = b[4];
    c.bytchk = b[1][1];
    c.fmt_bad = b[1][4] && (b[4] != 8'd0);
    c.diag_bad = b[1][4] || (b[3] != 8'd0) || (b[4] != 8'd0);
    if (in_tuser) begin
      c.op = sbcc_pkg::OP_CHANGE;
    end else begin
      case (cmd)
        8'h04: c.op = sbcc_pkg::OP_FORMAT;
        8'h08, 8'h0A: begin
          c.op = sbcc_pkg::OP_XFER;
          c.kind = (cmd == 8'h08) ? sbcc_pkg::K_READ : sbcc_pkg::K_WRITE;
          c.start = {43'd0, b[1][4:0], b[2], b[3]};
          c.count = (b[4] == 8'd0) ? 33'h100 : {25'd0, b[4]};
        end
        8'h0B: begin
          c.op = sbcc_pkg::OP_SEEK;
          c.start = {43'd0, b[1][4:0], b[2], b[3]};
        end
        8'h2B: begin
          c.op = sbcc_pkg::OP_SEEK;
          c.start = {32'd0, b[2], b[3], b[4], b[5]};
        end
        8'h28, 8'h2A, 8'h2F: begin
          c.op = sbcc_pkg::OP_XFER;
          c.kind = (cmd == 8'h28) ? sbcc_pkg::K_READ :
                   (cmd == 8'h2A) ? sbcc_pkg::K_WRITE : sbcc_pkg::K_VERIFY;
          c.start = {32'd0, b[2], b[3], b[4], b[5]};
          c.count = {17'd0, b[7], b[8]};
        end
        8'h88, 8'h8A, 8'h8F: begin
          c.op = sbcc_pkg::OP_XFER;
          c.kind = (cmd == 8'h88) ? sbcc_pkg::K_READ :
                   (cmd == 8'h8A) ? sbcc_pkg::K_WRITE : sbcc_pkg::K_VERIFY;
          c.start = {b[2], b[3], b[4], b[5], b[6], b[7], b[8], b[9]};
          c.count = {1'b0, b[10], b[11], b[12], b[13]};
        end
        8'h1B: c.op = sbcc_pkg::OP_STSP;
        8'h1D: c.op = sbcc_pkg::OP_DIAG;
        8'h1E: c.op = sbcc_pkg::OP_LOCK;
        8'h25: c.op = sbcc_pkg::OP_CAP;
        8'h3E, 8'h3F: begin
          c.op = sbcc_pkg::OP_LONG;
          c.len_nz = ({b[7], b[8]} != 16'd0);
          c.start = {32'd0, b[2], b[3], b[4], b[5]};
        end
        8'h9F: begin
          c.op = sbcc_pkg::OP_LONG;
          c.len_nz = ({b[12], b[13]} != 16'd0);
          c.start = {b[2], b[3], b[4], b[5], b[6], b[7], b[8], b[9]};
        end
        8'h9E: begin
          case (b[1][4:0])
            5'h10: begin
              c.op = sbcc_pkg::OP_CAP;
              c.wide = 1'b1;
            end
            5'h11: begin
              c.op = sbcc_pkg::OP_LONG;
              c.len_nz = ({b[12], b[13]} != 16'd0);
              c.start = {b[2], b[3], b[4], b[5], b[6], b[7], b[8], b[9]};
            end
            default: c.op = sbcc_pkg::OP_BADSA;
          endcase
        end
        default: c.op = sbcc_pkg::OP_BADOP;
      endcase
    end
  end

  assign in_tready = (cnt_r != 2'(sbcc_pkg::QDEPTH));
  assign push = in_tvalid && in_tready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_data = mem_r[rp_r];

  always_comb begin
    wp_nxt = push ? ~wp_r : wp_r;
    rp_nxt = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(sbcc_pkg::QDEPTH)) else $error("queue count overflow");
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'(sbcc_pkg::QDEPTH)) |-> !in_tready) else $error("full queue accepts");
endmodule
`default_nettype wire

### sv/sbcc_back.sv
// Back end of the SCSI block command checker: executes class records against
// the configuration and unit state, and holds the result register. Uses sbcc_pkg.
`default_nettype none
module sbcc_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  sbcc_pkg::cfg_t     cfg,
  input  wire logic          q_valid,
  input  sbcc_pkg::cls_t     q_data,
  output logic               q_pop,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output sbcc_pkg::res_t     res
);
  sbcc_pkg::res_t r, res_r;
  logic vld_r;
  logic lock_r, lock_nxt, stop_r, stop_nxt, pend_r, pend_nxt;
  logic [64:0] tot, endb;
  logic [12:0] bb;
  logic [47:0] lastb;
  logic st, ld;

  assign tot = {17'd0, cfg.block_total};
  assign endb = {1'b0, q_data.start} + {32'd0, q_data.count};
  assign lastb = cfg.block_total - 48'd1;
  assign st = q_data.b4[0];
  assign ld = q_data.b4[1];

  always_comb begin
    case (cfg.sector_shift)
      4'd10: bb = 13'd1024;
      4'd11: bb = 13'd2048;
      4'd12, 4'd13, 4'd14, 4'd15: bb = 13'd4096;
      default: bb = 13'd512;
    endcase
  end

  always_comb begin
    r = '0;
    lock_nxt = lock_r;
    stop_nxt = stop_r;
    pend_nxt = pend_r;
    if (q_data.op == sbcc_pkg::OP_CHANGE) begin
      if (cfg.removable) pend_nxt = 1'b1;
    end else if (pend_r) begin
      pend_nxt = 1'b0;
      r.error = sbcc_pkg::ERR_CHANGED;
    end else begin
      case (q_data.op)
        sbcc_pkg::OP_FORMAT: begin
          if (!cfg.medium_ready) r.error = sbcc_pkg::ERR_NOT_READY;
          else if (q_data.fmt_bad) r.error = sbcc_pkg::ERR_FIELD;
        end
        sbcc_pkg::OP_XFER: begin
          r.start_block = q_data.start;
          r.block_count = q_data.count[31:0];
          if ({1'b0, q_data.start} > tot || endb > tot) r.error = sbcc_pkg::ERR_RANGE;
          else if (q_data.count == 33'd0) r.error = sbcc_pkg::ERR_GOOD;
          else if (q_data.kind == sbcc_pkg::K_VERIFY && !q_data.bytchk) begin
            if (!cfg.medium_ready) r.error = sbcc_pkg::ERR_NOT_READY;
          end else if (!cfg.medium_ready) r.error = sbcc_pkg::ERR_NOT_READY;
          else if ({1'b0, q_data.start} >= tot) r.error = sbcc_pkg::ERR_FIELD;
          else if (q_data.kind == sbcc_pkg::K_WRITE && cfg.wr_protect)
            r.error = sbcc_pkg::ERR_PROTECT;
          else begin
            r.transfer_bytes = bb;
            r.phase = (q_data.kind == sbcc_pkg::K_READ) ? sbcc_pkg::PH_IN
                                                         : sbcc_pkg::PH_OUT;
          end
        end
        sbcc_pkg::OP_SEEK: begin
          r.start_block = q_data.start;
          if ({1'b0, q_data.start} > tot) r.error = sbcc_pkg::ERR_RANGE;
          else if (!cfg.medium_ready) r.error = sbcc_pkg::ERR_NOT_READY;
        end
        sbcc_pkg::OP_LONG: begin
          if (q_data.len_nz) r.error = sbcc_pkg::ERR_FIELD;
          else begin
            r.start_block = q_data.start;
            if ({1'b0, q_data.start} > tot) r.error = sbcc_pkg::ERR_RANGE;
          end
        end
        sbcc_pkg::OP_CAP: begin
          if (!cfg.medium_ready) r.error = sbcc_pkg::ERR_NOT_READY;
          else if (cfg.block_total == 48'd0) r.error = sbcc_pkg::ERR_NO_MEDIUM;
          else begin
            if (!q_data.wide && lastb[47:32] != 16'd0) r.last_block = 64'hFFFF_FFFF;
            else r.last_block = {16'd0, lastb};
            r.block_bytes = bb;
            r.transfer_bytes = q_data.wide ? 13'd14 : 13'd8;
            r.phase = sbcc_pkg::PH_IN;
          end
        end
        sbcc_pkg::OP_STSP: begin
          if (!ld) stop_nxt = !st;
          if (!st) begin
            r.flush_request = 1'b1;
            if (ld) begin
              if (lock_r || !cfg.medium_ready || !cfg.removable)
                r.error = sbcc_pkg::ERR_EJECT;
              else begin
                r.eject_request = 1'b1;
                stop_nxt = 1'b1;
                lock_nxt = 1'b0;
              end
            end
          end
        end
        sbcc_pkg::OP_DIAG: if (q_data.diag_bad) r.error = sbcc_pkg::ERR_FIELD;
        sbcc_pkg::OP_LOCK: begin
          if (!cfg.medium_ready) r.error = sbcc_pkg::ERR_NOT_READY;
          else lock_nxt = q_data.b4[0];
        end
        sbcc_pkg::OP_BADSA: r.error = sbcc_pkg::ERR_FIELD;
        default: r.error = sbcc_pkg::ERR_OPCODE;
      endcase
    end
    r.unit_stopped = stop_nxt;
  end

  assign q_pop = q_valid && (!vld_r || out_tready);
  assign out_tvalid = vld_r;
  assign res = res_r;

  always_ff @(posedge clk) begin
    if (q_pop) res_r <= r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      lock_r <= 1'b0;
      stop_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      if (q_pop) begin
        vld_r <= 1'b1;
        lock_r <= lock_nxt;
        stop_r <= stop_nxt;
        pend_r <= pend_nxt;
      end else if (out_tready) begin
        vld_r <= 1'b0;
      end
    end
  end

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && res_r.error != sbcc_pkg::ERR_GOOD) |->
    (res_r.phase == sbcc_pkg::PH_STATUS && res_r.transfer_bytes == 13'd0))
    else $error("error result with data phase");
  a_eject_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && res_r.eject_request) |-> res_r.unit_stopped)
    else $error("eject without stop");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && !out_tready) |=> $stable(res_r)) else $error("result changed in stall");
endmodule
`default_nettype wire

### sv/scsi_block_command_checker.sv
// Top level of the SCSI block command checker: configuration registers on an
// APB-style port, front-end decoder with queue, and back-end executor.
// Every descriptor or media-change notice gives exactly one result, and one
// transfer per cycle is taken back to back while in_tready is high. out_tvalid
// rises once the input transfer has passed through the two-entry queue and then
// the result register. in_tready drops only while the queue is full because the
// result register is held by a low out_tready.
`default_nettype none
module scsi_block_command_checker (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,   // cmd[7:0], cdb_head[71:8], cdb_tail[127:72]
  input  wire logic         in_tuser,   // media_change
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // error[3:0], phase[5:4], start_block[69:6], block_count[101:70],
  // transfer_bytes[114:102], last_block[178:115], block_bytes[191:179],
  // flush_request[192], eject_request[193], unit_stopped[194]
  output logic [199:0]      out_tdata,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [5:0]   cfg_paddr,
  input  wire logic [63:0]  cfg_pwdata,
  output logic [63:0]       cfg_prdata,
  output logic              cfg_pready
);
  sbcc_pkg::cfg_t cfg_r;
  sbcc_pkg::cls_t q_data;
  sbcc_pkg::res_t res;
  logic q_valid, q_pop, wr;
  logic [2:0] idx;

  assign cfg_pready = 1'b1;
  assign idx = cfg_paddr[5:3];
  assign wr = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2:0] == 3'd0);

  always_comb begin
    case (idx)
      sbcc_pkg::REG_TOTAL:   cfg_prdata = {16'd0, cfg_r.block_total};
      sbcc_pkg::REG_SHIFT:   cfg_prdata = {60'd0, cfg_r.sector_shift};
      sbcc_pkg::REG_PROTECT: cfg_prdata = {63'd0, cfg_r.wr_protect};
      sbcc_pkg::REG_READY:   cfg_prdata = {63'd0, cfg_r.medium_ready};
      sbcc_pkg::REG_REMOV:   cfg_prdata = {63'd0, cfg_r.removable};
      default:               cfg_prdata = 64'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.block_total <= 48'd0;
      cfg_r.sector_shift <= 4'd9;
      cfg_r.wr_protect <= 1'b0;
      cfg_r.medium_ready <= 1'b0;
      cfg_r.removable <= 1'b0;
    end else if (wr) begin
      case (idx)
        sbcc_pkg::REG_TOTAL:   cfg_r.block_total <= cfg_pwdata[47:0];
        sbcc_pkg::REG_SHIFT:   cfg_r.sector_shift <= cfg_pwdata[3:0];
        sbcc_pkg::REG_PROTECT: cfg_r.wr_protect <= cfg_pwdata[0];
        sbcc_pkg::REG_READY:   cfg_r.medium_ready <= cfg_pwdata[0];
        sbcc_pkg::REG_REMOV:   cfg_r.removable <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  sbcc_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .q_pop, .q_valid, .q_data
  );

  sbcc_back u_back (
    .clk, .rst_n, .cfg(cfg_r), .q_valid, .q_data, .q_pop,
    .out_tvalid, .out_tready, .res
  );

  assign out_tdata = {5'd0, res.unit_stopped, res.eject_request, res.flush_request,
                      res.block_bytes, res.last_block, res.transfer_bytes,
                      res.block_count, res.start_block, res.phase, res.error};
endmodule
`default_nettype wire

### verif/tb.sv
// Self-checking testbench for scsi_block_command_checker: drives descriptors over
// the input stream, predicts every result in place and checks the result stream.
// Depends on sbcc_pkg and the block's RTL only.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] OP_FMT = 8'h04, OP_RD6 = 8'h08, OP_WR6 = 8'h0A, OP_SK6 = 8'h0B;
  localparam logic [7:0] OP_STOP = 8'h1B, OP_SDIAG = 8'h1D, OP_PREV = 8'h1E;
  localparam logic [7:0] OP_CAP10 = 8'h25, OP_RD10 = 8'h28, OP_WR10 = 8'h2A;
  localparam logic [7:0] OP_SK10 = 8'h2B, OP_VF10 = 8'h2F, OP_RL10 = 8'h3E, OP_WL10 = 8'h3F;
  localparam logic [7:0] OP_RD16 = 8'h88, OP_WR16 = 8'h8A, OP_VF16 = 8'h8F;
  localparam logic [7:0] OP_SAI = 8'h9E, OP_WL16 = 8'h9F;
  localparam logic [4:0] SA_CAP16 = 5'h10, SA_RL16 = 5'h11;

  typedef struct {
    logic [7:0]  op;
    logic [63:0] head;
    logic [55:0] tail;
    logic        mc;
  } cdb_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, in_tuser;
  logic [127:0] in_tdata;
  logic out_tvalid, out_tready;
  logic [199:0] out_tdata;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [5:0] cfg_paddr;
  logic [63:0] cfg_pwdata, cfg_prdata;

  scsi_block_command_checker i_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata, .cfg_pready
  );

  // Predictor copy of the registers and the unit state.
  logic [47:0] m_total;
  logic [3:0]  m_shift;
  logic        m_wp, m_ready, m_remov;
  logic        m_locked, m_stopped, m_pending;

  cdb_t            cdb_q[$];
  sbcc_pkg::res_t  answer_q[$];
  int    gap, rx_gap, mismatches, checked, sent, errs_seen[16];
  bit    quiet, rx_hold, rx_hold_req;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic logic [7:0] cb(logic [63:0] hd, logic [55:0] tl, int i);
    if (i >= 1 && i <= 8) return hd[(8 - i) * 8 +: 8];
    if (i >= 9 && i <= 15) return tl[(15 - i) * 8 +: 8];
    return 8'h00;
  endfunction

  function automatic logic [63:0] cf(logic [63:0] hd, logic [55:0] tl, int first, int n);
    logic [63:0] v;
    v = 0;
    for (int k = 0; k < n; k++) v = {v[55:0], cb(hd, tl, first + k)};
    return v;
  endfunction

  function automatic logic [12:0] sector_bytes();
    int s;
    s = m_shift;
    if (s < 9) s = 9;
    if (s > 12) s = 12;
    return 13'(1 << s);
  endfunction

  function automatic logic fits(logic [63:0] s, logic [63:0] n);
    return s <= m_total && s + n <= m_total;
  endfunction

  function automatic sbcc_pkg::res_t move_blocks(sbcc_pkg::res_t r, logic [1:0] kind,
                                                 logic [63:0] s, logic [63:0] n,
                                                 logic [7:0] b1);
    r.start_block = s;
    r.block_count = n[31:0];
    if (!fits(s, n)) r.error = sbcc_pkg::ERR_RANGE;
    else if (n == 0) ;
    else if (kind == sbcc_pkg::K_VERIFY && !b1[1]) begin
      if (!m_ready) r.error = sbcc_pkg::ERR_NOT_READY;
    end else if (!m_ready) r.error = sbcc_pkg::ERR_NOT_READY;
    else if (s >= m_total) r.error = sbcc_pkg::ERR_FIELD;
    else if (kind == sbcc_pkg::K_WRITE && m_wp) r.error = sbcc_pkg::ERR_PROTECT;
    else begin
      r.transfer_bytes = sector_bytes();
      r.phase = (kind == sbcc_pkg::K_READ) ? sbcc_pkg::PH_IN : sbcc_pkg::PH_OUT;
    end
    return r;
  endfunction

  function automatic sbcc_pkg::res_t seek_to(sbcc_pkg::res_t r, logic [63:0] s);
    r.start_block = s;
    if (!fits(s, 0)) r.error = sbcc_pkg::ERR_RANGE;
    else if (!m_ready) r.error = sbcc_pkg::ERR_NOT_READY;
    return r;
  endfunction

  function automatic sbcc_pkg::res_t long_access(sbcc_pkg::res_t r, logic [63:0] len,
                                                 logic [63:0] s);
    if (len != 0) r.error = sbcc_pkg::ERR_FIELD;
    else begin
      r.start_block = s;
      if (s > m_total) r.error = sbcc_pkg::ERR_RANGE;
    end
    return r;
  endfunction

  function automatic sbcc_pkg::res_t capacity(sbcc_pkg::res_t r, logic wide);
    logic [63:0] last;
    if (!m_ready) r.error = sbcc_pkg::ERR_NOT_READY;
    else if (m_total == 0) r.error = sbcc_pkg::ERR_NO_MEDIUM;
    else begin
      last = 64'(m_total) - 1;
      if (!wide && last > 64'hFFFF_FFFF) last = 64'hFFFF_FFFF;
      r.last_block = last;
      r.block_bytes = sector_bytes();
      r.transfer_bytes = wide ? 13'd14 : 13'd8;
      r.phase = sbcc_pkg::PH_IN;
    end
    return r;
  endfunction

  function automatic sbcc_pkg::res_t decode_command(sbcc_pkg::res_t r, cdb_t c);
    logic [63:0] hd;
    logic [55:0] tl;
    logic [7:0]  b1, b4;
    logic [63:0] n;
    hd = c.head;
    tl = c.tail;
    b1 = cb(hd, tl, 1);
    b4 = cb(hd, tl, 4);
    case (c.op)
      OP_FMT: begin
        if (!m_ready) r.error = sbcc_pkg::ERR_NOT_READY;
        else if (b1[4] && b4 != 0) r.error = sbcc_pkg::ERR_FIELD;
      end
      OP_RD6, OP_WR6: begin
        n = (b4 == 0) ? 64'h100 : 64'(b4);
        r = move_blocks(r, (c.op == OP_RD6) ? sbcc_pkg::K_READ : sbcc_pkg::K_WRITE,
                        cf(hd, tl, 1, 3) & 64'h1F_FFFF, n, b1);
      end
      OP_SK6:  r = seek_to(r, cf(hd, tl, 1, 3) & 64'h1F_FFFF);
      OP_SK10: r = seek_to(r, cf(hd, tl, 2, 4));
      OP_RD10: r = move_blocks(r, sbcc_pkg::K_READ, cf(hd, tl, 2, 4), cf(hd, tl, 7, 2), b1);
      OP_WR10: r = move_blocks(r, sbcc_pkg::K_WRITE, cf(hd, tl, 2, 4), cf(hd, tl, 7, 2), b1);
      OP_VF10: r = move_blocks(r, sbcc_pkg::K_VERIFY, cf(hd, tl, 2, 4), cf(hd, tl, 7, 2), b1);
      OP_RD16: r = move_blocks(r, sbcc_pkg::K_READ, cf(hd, tl, 2, 8), cf(hd, tl, 10, 4), b1);
      OP_WR16: r = move_blocks(r, sbcc_pkg::K_WRITE, cf(hd, tl, 2, 8), cf(hd, tl, 10, 4), b1);
      OP_VF16: r = move_blocks(r, sbcc_pkg::K_VERIFY, cf(hd, tl, 2, 8), cf(hd, tl, 10, 4),
                               b1);
      OP_STOP: begin
        if (!b4[1]) m_stopped = !b4[0];
        if (!b4[0]) begin
          r.flush_request = 1;
          if (b4[1]) begin
            if (m_locked || !m_ready || !m_remov) r.error = sbcc_pkg::ERR_EJECT;
            else begin
              r.eject_request = 1;
              m_stopped = 1;
              m_locked = 0;
            end
          end
        end
      end
      OP_SDIAG:
        if (b1[4] || cb(hd, tl, 3) != 0 || b4 != 0) r.error = sbcc_pkg::ERR_FIELD;
      OP_PREV: begin
        if (!m_ready) r.error = sbcc_pkg::ERR_NOT_READY;
        else m_locked = b4[0];
      end
      OP_CAP10: r = capacity(r, 0);
      OP_RL10, OP_WL10: r = long_access(r, cf(hd, tl, 7, 2), cf(hd, tl, 2, 4));
      OP_WL16: r = long_access(r, cf(hd, tl, 12, 2), cf(hd, tl, 2, 8));
      OP_SAI: begin
        if (b1[4:0] == SA_CAP16) r = capacity(r, 1);
        else if (b1[4:0] == SA_RL16) r = long_access(r, cf(hd, tl, 12, 2), cf(hd, tl, 2, 8));
        else r.error = sbcc_pkg::ERR_FIELD;
      end
      default: r.error = sbcc_pkg::ERR_OPCODE;
    endcase
    return r;
  endfunction

  function automatic sbcc_pkg::res_t predict_status(cdb_t c);
    sbcc_pkg::res_t r;
    r = '0;
    if (c.mc) begin
      if (m_remov) m_pending = 1;
    end else if (m_pending) begin
      m_pending = 0;
      r.error = sbcc_pkg::ERR_CHANGED;
    end else r = decode_command(r, c);
    if (r.error != sbcc_pkg::ERR_GOOD) begin
      r.phase = sbcc_pkg::PH_STATUS;
      r.transfer_bytes = 0;
      r.last_block = 0;
      r.block_bytes = 0;
    end
    r.unit_stopped = m_stopped;
    return r;
  endfunction

  // Sender: accepted descriptors are predicted at the edge that moves them.
  always @(posedge clk) begin
    cdb_t c;
    if (!rst_n) begin
      in_tvalid <= 0;
      in_tdata  <= '0;
      in_tuser  <= 0;
      gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        c.op = in_tdata[7:0];
        c.head = in_tdata[71:8];
        c.tail = in_tdata[127:72];
        c.mc = in_tuser;
        answer_q.push_back(predict_status(c));
        sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap > 0) begin
          gap--;
          in_tvalid <= 0;
        end else if (cdb_q.size() > 0) begin
          c = cdb_q.pop_front();
          in_tdata  <= {c.tail, c.head, c.op};
          in_tuser  <= c.mc;
          in_tvalid <= 1;
          if (!quiet && $urandom_range(0, 9) == 0) gap = $urandom_range(1, 4);
        end else in_tvalid <= 0;
      end
    end
  end

  // Receiver: every transfer is compared against the oldest prediction.
  always @(posedge clk) begin
    sbcc_pkg::res_t e, a;
    if (!rst_n) begin
      out_tready <= 0;
      rx_gap = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        a.error = out_tdata[3:0];
        a.phase = out_tdata[5:4];
        a.start_block = out_tdata[69:6];
        a.block_count = out_tdata[101:70];
        a.transfer_bytes = out_tdata[114:102];
        a.last_block = out_tdata[178:115];
        a.block_bytes = out_tdata[191:179];
        a.flush_request = out_tdata[192];
        a.eject_request = out_tdata[193];
        a.unit_stopped = out_tdata[194];
        if (answer_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("tb: result with nothing expected: %h", out_tdata);
        end else begin
          e = answer_q.pop_front();
          checked++;
          errs_seen[e.error]++;
          if (a.error !== e.error || a.phase !== e.phase || a.start_block !== e.start_block ||
              a.block_count !== e.block_count || a.transfer_bytes !== e.transfer_bytes ||
              a.last_block !== e.last_block || a.block_bytes !== e.block_bytes ||
              a.flush_request !== e.flush_request || a.eject_request !== e.eject_request ||
              a.unit_stopped !== e.unit_stopped) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("tb: mismatch on result %0d", checked);
              $display("  expected err=%0d ph=%0d lba=%h cnt=%h by=%0d last=%h bb=%0d f=%b e=%b s=%b",
                       e.error, e.phase, e.start_block, e.block_count, e.transfer_bytes,
                       e.last_block, e.block_bytes, e.flush_request, e.eject_request,
                       e.unit_stopped);
              $display("  actual   err=%0d ph=%0d lba=%h cnt=%h by=%0d last=%h bb=%0d f=%b e=%b s=%b",
                       a.error, a.phase, a.start_block, a.block_count, a.transfer_bytes,
                       a.last_block, a.block_bytes, a.flush_request, a.eject_request,
                       a.unit_stopped);
            end
          end
        end
      end
      if (rx_hold) out_tready <= 0;
      else if (rx_gap > 0) begin
        rx_gap--;
        out_tready <= 0;
      end else begin
        out_tready <= 1;
        if (!quiet && $urandom_range(0, 7) == 0) rx_gap = $urandom_range(1, 4);
      end
    end
  end

  // Long receiver hold-off, timed in its own process.
  initial begin
    rx_hold = 0;
    wait (rx_hold_req);
    @(negedge clk);
    rx_hold = 1;
    repeat (200) @(negedge clk);
    rx_hold = 0;
  end

  initial begin
    #20ms;
    $display("tb: FAIL");
    $finish;
  end

  task automatic reg_write(logic [2:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_psel    <= 1;
    cfg_penable <= 0;
    cfg_pwrite  <= 1;
    cfg_paddr   <= 6'(idx * 8);
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel    <= 0;
    cfg_penable <= 0;
    cfg_pwrite  <= 0;
    case (idx)
      sbcc_pkg::REG_TOTAL:   m_total = val[47:0];
      sbcc_pkg::REG_SHIFT:   m_shift = val[3:0];
      sbcc_pkg::REG_PROTECT: m_wp = val[0];
      sbcc_pkg::REG_READY:   m_ready = val[0];
      sbcc_pkg::REG_REMOV:   m_remov = val[0];
      default: ;
    endcase
  endtask

  task automatic set_medium(logic [47:0] total, logic [3:0] shift, logic wp, logic rdy,
                            logic rem);
    reg_write(sbcc_pkg::REG_TOTAL, {16'hFFFF, total});
    reg_write(sbcc_pkg::REG_SHIFT, {60'h0, shift});
    reg_write(sbcc_pkg::REG_PROTECT, {63'h0, wp});
    reg_write(sbcc_pkg::REG_READY, {63'h0, rdy});
    reg_write(sbcc_pkg::REG_REMOV, {63'h0, rem});
  endtask

  task automatic drain();
    do @(negedge clk);
    while (cdb_q.size() != 0 || in_tvalid || answer_q.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  function automatic cdb_t pack_cdb(logic [7:0] op, logic [7:0] b[1:15], logic mc);
    cdb_t c;
    c.op = op;
    c.mc = mc;
    for (int i = 1; i <= 8; i++) c.head[(8 - i) * 8 +: 8] = b[i];
    for (int i = 9; i <= 15; i++) c.tail[(15 - i) * 8 +: 8] = b[i];
    return c;
  endfunction

  function automatic void put_field(ref logic [7:0] b[1:15], input int first, input int n,
                                    input logic [63:0] v);
    for (int k = n - 1; k >= 0; k--) begin
      b[first + k] = v[7:0];
      v = v >> 8;
    end
  endfunction

  function automatic logic [63:0] pick_lba();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 64'(m_total);
      2: return 64'(m_total) + 1;
      3: return 64'(m_total) - $urandom_range(0, 3);
      4: return {$urandom, $urandom};
      default: return 64'($urandom_range(0, 300));
    endcase
  endfunction

  function automatic logic [63:0] pick_count();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return {32'h0, $urandom};
      default: return 64'($urandom_range(1, 20));
    endcase
  endfunction

  function automatic cdb_t random_cdb();
    logic [7:0] ops[22] = '{OP_FMT, OP_RD6, OP_WR6, OP_SK6, OP_STOP, OP_SDIAG, OP_PREV,
                            OP_CAP10, OP_RD10, OP_WR10, OP_SK10, OP_VF10, OP_RL10, OP_WL10,
                            OP_RD16, OP_WR16, OP_VF16, OP_SAI, OP_WL16, OP_PREV, OP_STOP,
                            OP_SAI};
    logic [7:0] b[1:15];
    logic [7:0] op;
    logic [63:0] lba;
    int sel;
    for (int i = 1; i <= 15; i++) b[i] = 8'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 4) return pack_cdb(8'($urandom), b, 1);
    if (sel < 9) return pack_cdb(8'($urandom), b, 0);
    op = ops[$urandom_range(0, 21)];
    if ($urandom_range(0, 4) == 0) return pack_cdb(op, b, 0);
    lba = pick_lba();
    case (op)
      OP_RD6, OP_WR6, OP_SK6: begin
        put_field(b, 1, 3, {b[1][7:5], lba[20:0]});
        if ($urandom_range(0, 3) == 0) b[4] = 0;
        else b[4] = 8'($urandom_range(0, 20));
      end
      OP_RD10, OP_WR10, OP_VF10, OP_SK10: begin
        put_field(b, 2, 4, lba);
        put_field(b, 7, 2, pick_count());
      end
      OP_RL10, OP_WL10: begin
        put_field(b, 2, 4, lba);
        if ($urandom_range(0, 3) != 0) put_field(b, 7, 2, 0);
      end
      OP_RD16, OP_WR16, OP_VF16: begin
        put_field(b, 2, 8, lba);
        put_field(b, 10, 4, pick_count());
      end
      OP_SAI, OP_WL16: begin
        if (op == OP_SAI && $urandom_range(0, 5) != 0)
          b[1][4:0] = $urandom_range(0, 1) ? SA_CAP16 : SA_RL16;
        put_field(b, 2, 8, lba);
        if ($urandom_range(0, 3) != 0) put_field(b, 12, 2, 0);
      end
      OP_STOP: b[4] = {6'($urandom), 2'($urandom)};
      OP_SDIAG, OP_FMT:
        if ($urandom_range(0, 1) != 0) begin
          b[3] = 0;
          b[4] = 0;
        end
      default: ;
    endcase
    return pack_cdb(op, b, 0);
  endfunction

  task automatic add_cmd(logic [7:0] op, logic [63:0] hd, logic [55:0] tl, logic mc);
    cdb_t c;
    c.op = op;
    c.head = hd;
    c.tail = tl;
    c.mc = mc;
    cdb_q.push_back(c);
  endtask

  task automatic random_run(int n);
    for (int i = 0; i < n; i++) cdb_q.push_back(random_cdb());
  endtask

  initial begin
    rst_n = 0;
    quiet = 0;
    rx_hold_req = 0;
    mismatches = 0;
    checked = 0;
    sent = 0;
    cfg_psel = 0;
    cfg_penable = 0;
    cfg_pwrite = 0;
    cfg_paddr = 0;
    cfg_pwdata = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tuser = 0;
    out_tready = 0;
    m_total = 0;
    m_shift = 9;
    m_wp = 0;
    m_ready = 0;
    m_remov = 0;
    m_locked = 0;
    m_stopped = 0;
    m_pending = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;

    // Reset settings: nothing ready, no medium.
    add_cmd(OP_CAP10, 0, 0, 0);
    add_cmd(OP_RD10, 64'h0000_0000_0000_0100, 0, 0);
    add_cmd(OP_PREV, 64'h0000_0001_0000_0000, 0, 0);
    drain();

    set_medium(48'd1000, 4'd9, 1'b0, 1'b1, 1'b1);
    add_cmd(OP_RD6, 64'h0000_0000_0000_0000, 0, 0);
    add_cmd(OP_WR6, 64'h0003_E000_0000_0000, 0, 0);
    add_cmd(OP_RD10, 64'h0000_0003_E600_0200, 0, 0);
    add_cmd(OP_RD10, 64'h0000_0003_E800_0000, 0, 0);
    add_cmd(OP_VF10, 64'h0000_0000_1000_0004, 0, 0);
    add_cmd(OP_VF10, 64'h0200_0000_1000_0004, 0, 0);
    add_cmd(OP_WR16, 64'h0000_0000_0000_0000, 56'h00_0000_0001_0000, 0);
    add_cmd(OP_SK10, 64'h0000_0003_E900_0000, 0, 0);
    add_cmd(OP_SAI, {8'h10, 56'h0}, 0, 0);
    add_cmd(OP_SAI, {8'h1F, 56'h0}, 0, 0);
    add_cmd(OP_SAI, {8'h11, 56'h0}, 56'h00_0000_0001_0000, 0);
    add_cmd(OP_RL10, 64'h0000_0000_0500_0000, 0, 0);
    add_cmd(OP_PREV, 64'h0000_0001_0000_0000, 0, 0);
    add_cmd(OP_STOP, 64'h0000_0002_0000_0000, 0, 0);
    add_cmd(OP_PREV, 64'h0000_0000_0000_0000, 0, 0);
    add_cmd(OP_STOP, 64'h0000_0000_0000_0000, 0, 0);
    add_cmd(OP_STOP, 64'h0000_0001_0000_0000, 0, 0);
    add_cmd(OP_STOP, 64'h0000_0002_0000_0000, 0, 0);
    add_cmd(OP_SDIAG, 64'h1000_0000_0000_0000, 0, 0);
    add_cmd(OP_FMT, 64'h1000_0001_0000_0000, 0, 0);
    add_cmd(8'hFF, '1, '1, 0);
    add_cmd(8'h00, '1, '1, 1);
    add_cmd(OP_RD10, '1, '1, 0);
    add_cmd(8'hFF, 0, 0, 0);
    drain();

    random_run(300);
    drain();
    set_medium(48'hFFFF_FFFF_FFFF, 4'd12, 1'b1, 1'b1, 1'b1);
    random_run(150);
    drain();
    rx_hold_req = 1;
    random_run(150);
    drain();
    set_medium(48'd0, 4'd0, 1'b0, 1'b1, 1'b0);
    random_run(250);
    drain();
    set_medium(48'h2_0000_0005, 4'd15, 1'b0, 1'b0, 1'b1);
    random_run(250);
    drain();
    set_medium(48'd5000, 4'd10, 1'b1, 1'b1, 1'b0);
    random_run(300);
    drain();
    set_medium(48'd300, 4'd11, 1'b0, 1'b1, 1'b1);
    quiet = 1;
    random_run(350);
    drain();
    repeat (20) @(posedge clk);

    $display("tb: %0d descriptors sent, %0d results checked over seven medium settings",
             sent, checked);
    $display("tb: status counts good=%0d changed=%0d range=%0d opcode=%0d, %0d mismatches",
             errs_seen[sbcc_pkg::ERR_GOOD], errs_seen[sbcc_pkg::ERR_CHANGED],
             errs_seen[sbcc_pkg::ERR_RANGE], errs_seen[sbcc_pkg::ERR_OPCODE], mismatches);
    if (mismatches == 0 && answer_q.size() == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end
endmodule
`default_nettype wire
